/* hw/rtl/wsfr_pkg.sv */
// Shared types and constants for the WebSocket frame receiver.
package wsfr_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [3:0] OPCODE_CLOSE = 4'h8;
   localparam logic [3:0] OPCODE_PING  = 4'h9;
   localparam logic [6:0] LEN7_EXT16   = 7'd126;
   localparam logic [6:0] LEN7_EXT64   = 7'd127;
   localparam logic [7:0] PONG_HEAD    = 8'h8A;

   typedef enum logic [2:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_PONG    = 3'd1,
      KIND_CLOSE   = 3'd2,
      KIND_LONG    = 3'd3,
      KIND_EMPTY   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT_HI,
      PH_EXT_LO,
      PH_KEY,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } cmd_type;

endpackage

/* hw/rtl/wsfr_front.sv */
// Header parser and unmasker: turns each received byte into at most one command.
module wsfr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       rx_byte,
   output logic             push_valid,
   output wsfr_pkg::cmd_type push_cmd
);
   import wsfr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        text_ff, text_in;
   logic        masked_ff, masked_in;
   logic        halted_ff, halted_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [1:0]  key_index_ff, key_index_in;
   logic [7:0]  mask_key_ff [4];

   logic [3:0]  opcode;
   logic [6:0]  len7;
   logic        is_ping;
   logic [15:0] ext_len;

   assign opcode  = rx_byte[3:0];
   assign len7    = rx_byte[6:0];
   assign is_ping = (opcode == OPCODE_PING);
   assign ext_len = {remaining_ff[15:8], rx_byte};

   // next state
   always_comb begin
      phase_in     = phase_ff;
      text_in      = text_ff;
      masked_in    = masked_ff;
      halted_in    = halted_ff;
      remaining_in = remaining_ff;
      key_index_in = key_index_ff;
      if (take && !halted_ff) begin
         unique case (phase_ff)
            PH_HDR0: begin
               if (opcode == OPCODE_CLOSE) begin
                  halted_in = 1'b1;
               end else begin
                  text_in  = !is_ping && opcode[0];
                  phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               masked_in    = rx_byte[7];
               key_index_in = 2'd0;
               if (len7 == LEN7_EXT64) begin
                  halted_in = 1'b1;
                  phase_in  = PH_HDR0;
               end else if (len7 == LEN7_EXT16) begin
                  phase_in = PH_EXT_HI;
               end else begin
                  remaining_in = {9'd0, len7};
                  if (rx_byte[7]) begin
                     phase_in = PH_KEY;
                  end else begin
                     phase_in = (len7 == 7'd0) ? PH_HDR0 : PH_PAYLOAD;
                  end
               end
            end
            PH_EXT_HI: begin
               remaining_in = {rx_byte, 8'd0};
               phase_in     = PH_EXT_LO;
            end
            PH_EXT_LO: begin
               remaining_in = ext_len;
               key_index_in = 2'd0;
               if (masked_ff) begin
                  phase_in = PH_KEY;
               end else begin
                  phase_in = (ext_len == 16'd0) ? PH_HDR0 : PH_PAYLOAD;
               end
            end
            PH_KEY: begin
               key_index_in = key_index_ff + 2'd1;
               if (key_index_ff == 2'd3) begin
                  phase_in = (remaining_ff == 16'd0) ? PH_HDR0 : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               key_index_in = key_index_ff + 2'd1;
               remaining_in = remaining_ff - 16'd1;
               if (remaining_ff == 16'd1) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
      end
   end

   // command output
   always_comb begin
      push_valid    = 1'b0;
      push_cmd.kind = KIND_PAYLOAD;
      push_cmd.data = 8'd0;
      push_cmd.last = 1'b0;
      if (take && !halted_ff) begin
         unique case (phase_ff)
            PH_HDR0: begin
               if (opcode == OPCODE_CLOSE) begin
                  push_valid    = 1'b1;
                  push_cmd.kind = KIND_CLOSE;
               end else if (is_ping) begin
                  push_valid    = 1'b1;
                  push_cmd.kind = KIND_PONG;
               end
            end
            PH_HDR1: begin
               if (len7 == LEN7_EXT64) begin
                  push_valid    = 1'b1;
                  push_cmd.kind = KIND_LONG;
               end else if (len7 == 7'd0 && !rx_byte[7] && text_ff) begin
                  push_valid    = 1'b1;
                  push_cmd.kind = KIND_EMPTY;
               end
            end
            PH_EXT_LO: begin
               if (!masked_ff && ext_len == 16'd0 && text_ff) begin
                  push_valid    = 1'b1;
                  push_cmd.kind = KIND_EMPTY;
               end
            end
            PH_KEY: begin
               if (key_index_ff == 2'd3 && remaining_ff == 16'd0 && text_ff) begin
                  push_valid    = 1'b1;
                  push_cmd.kind = KIND_EMPTY;
               end
            end
            PH_PAYLOAD: begin
               if (text_ff) begin
                  push_valid    = 1'b1;
                  push_cmd.kind = KIND_PAYLOAD;
                  push_cmd.data = masked_ff ? (rx_byte ^ mask_key_ff[key_index_ff]) : rx_byte;
                  push_cmd.last = (remaining_ff == 16'd1);
               end
            end
            default: begin
               push_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         text_ff      <= 1'b0;
         masked_ff    <= 1'b0;
         halted_ff    <= 1'b0;
         remaining_ff <= 16'd0;
         key_index_ff <= 2'd0;
      end else begin
         phase_ff     <= phase_in;
         text_ff      <= text_in;
         masked_ff    <= masked_in;
         halted_ff    <= halted_in;
         remaining_ff <= remaining_in;
         key_index_ff <= key_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !halted_ff && phase_ff == PH_KEY) begin
         mask_key_ff[key_index_ff] <= rx_byte;
      end
   end

`ifndef SYNTH
   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !push_valid)
      else $error("command issued while parser halted");
`endif

endmodule

/* hw/rtl/wsfr_queue.sv */
// Short command queue between the parser and the result sequencer.
module wsfr_queue #(
   parameter int unsigned QUEUE_DEPTH = wsfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wsfr_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output wsfr_pkg::cmd_type head_cmd
);
   import wsfr_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign head_cmd = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count overflow");
`endif

endmodule

/* hw/rtl/wsfr_back.sv */
// Result sequencer: expands queued commands into result words and holds the output register.
module wsfr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  wsfr_pkg::cmd_type head_cmd,
   output logic              pop,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [2:0]        rsp_kind,
   output logic [7:0]        rsp_data,
   output logic              rsp_last
);
   import wsfr_pkg::*;

   logic       out_valid_ff, out_valid_in;
   cmd_type    out_ff, out_in;
   logic       pong_busy_ff, pong_busy_in;
   logic [1:0] pong_step_ff, pong_step_in;
   logic       load;

   assign load = !out_valid_ff || !rsp_stall;
   assign pop  = load && !pong_busy_ff && !empty;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      pong_busy_in = pong_busy_ff;
      pong_step_in = pong_step_ff;
      if (load) begin
         if (pong_busy_ff) begin
            out_valid_in = 1'b1;
            out_in.kind  = KIND_PONG;
            out_in.data  = 8'd0;
            out_in.last  = (pong_step_ff == 2'd3);
            pong_step_in = pong_step_ff + 2'd1;
            pong_busy_in = (pong_step_ff != 2'd3);
         end else if (!empty) begin
            out_valid_in = 1'b1;
            out_in       = head_cmd;
            if (head_cmd.kind == KIND_PONG) begin
               out_in.data  = PONG_HEAD;
               out_in.last  = 1'b0;
               pong_busy_in = 1'b1;
               pong_step_in = 2'd1;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pong_busy_ff <= 1'b0;
         pong_step_ff <= 2'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         pong_busy_ff <= pong_busy_in;
         pong_step_ff <= pong_step_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_ff.kind;
   assign rsp_data  = out_ff.data;
   assign rsp_last  = out_ff.last;

`ifndef SYNTH
   a_pong_tail: assert property (@(posedge clock) disable iff (reset)
      (pong_busy_ff && load) |=> (rsp_valid && rsp_kind == KIND_PONG && rsp_data == 8'd0))
      else $error("pong tail word malformed");
`endif

endmodule

/* hw/rtl/websocket_frame_receiver_core.sv */
// WebSocket frame receiver top level: parser, command queue and result sequencer.
// Takes one received stream byte per cycle while req_stall is low, and returns
// unmasked payload words of text-type frames, empty words for empty text frames,
// pong words for pings, and status words for close frames and 64-bit lengths
// (after which the parser ignores all input until reset). Each byte produces at
// most one queued command, and each command leaves as one result word per cycle
// while rsp_stall is low, except a ping, which leaves as four pong words. The
// command queue (QUEUE_DEPTH entries) sets how many commands may wait while the
// result side stalls; req_stall is high while it is full. A command passes
// through the queue and then the output register before its result appears.
module websocket_frame_receiver_core #(
   parameter int unsigned QUEUE_DEPTH = wsfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_data,
   output logic       rsp_last
);
   import wsfr_pkg::*;

   logic    take;
   logic    push_valid;
   cmd_type push_cmd;
   logic    full, empty, pop;
   cmd_type head_cmd;

   assign req_stall = full;
   assign take      = req_valid && !full;

   wsfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .rx_byte    (req_rx_byte),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   wsfr_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head_cmd (head_cmd)
   );

   wsfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_kind  (rsp_kind),
      .rsp_data  (rsp_data),
      .rsp_last  (rsp_last)
   );

endmodule

/* sim/websocket_frame_receiver_core_test.sv */
// Self-checking testbench for the WebSocket frame receiver core.
`timescale 1ns / 100ps

module websocket_frame_receiver_core_test;
   import wsfr_pkg::*;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] FIN_SET   = 4'h8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_data;
   logic       rsp_last;

   websocket_frame_receiver_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_kind    (rsp_kind),
      .rsp_data    (rsp_data),
      .rsp_last    (rsp_last)
   );

   // parser state mirror
   phase_type   prs_phase = PH_HDR0;
   logic        is_text = 1'b0;
   logic        is_ping = 1'b0;
   logic        is_masked = 1'b0;
   logic [15:0] bytes_left = 16'd0;
   logic [7:0]  key [4];
   logic [1:0]  key_pos = 2'd0;
   logic        stopped = 1'b0;

   cmd_type     expected_words [$];
   int unsigned errors = 0;
   int unsigned bytes_sent = 0;
   bit          idle_req = 1'b1;
   bit          idle_rsp = 1'b1;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("websocket_frame_receiver_core test failed");
      $finish;
   end

   function automatic int unsigned draw_gap(input bit on);
      return on ? $urandom_range(0, 19) : 0;
   endfunction

   task automatic push_word(input kind_type k, input logic [7:0] d, input logic l);
      expected_words.push_back(cmd_type'{kind: k, data: d, last: l});
   endtask

   task automatic finish_header();
      key_pos = 2'd0;
      if (bytes_left == 16'd0) begin
         if (is_text) push_word(KIND_EMPTY, 8'h00, 1'b0);
         prs_phase = PH_HDR0;
      end else begin
         prs_phase = PH_PAYLOAD;
      end
   endtask

   task automatic finish_length();
      if (is_masked) begin
         key_pos = 2'd0;
         prs_phase = PH_KEY;
      end else begin
         finish_header();
      end
   endtask

   task automatic model_byte(input logic [7:0] b);
      logic [3:0] op;
      if (stopped) return;
      case (prs_phase)
         PH_HDR1: begin
            is_masked = b[7];
            if (b[6:0] == LEN7_EXT64) begin
               stopped = 1'b1;
               prs_phase = PH_HDR0;
               push_word(KIND_LONG, 8'h00, 1'b0);
            end else if (b[6:0] == LEN7_EXT16) begin
               prs_phase = PH_EXT_HI;
            end else begin
               bytes_left = {9'd0, b[6:0]};
               finish_length();
            end
         end
         PH_EXT_HI: begin
            bytes_left = {b, 8'h00};
            prs_phase = PH_EXT_LO;
         end
         PH_EXT_LO: begin
            bytes_left[7:0] = b;
            finish_length();
         end
         PH_KEY: begin
            key[key_pos] = b;
            if (key_pos == 2'd3) finish_header();
            else key_pos++;
         end
         PH_PAYLOAD: begin
            if (is_text)
               push_word(KIND_PAYLOAD, is_masked ? b ^ key[key_pos] : b, bytes_left == 16'd1);
            key_pos++;
            bytes_left--;
            if (bytes_left == 16'd0) prs_phase = PH_HDR0;
         end
         default: begin
            op = b[3:0];
            prs_phase = PH_HDR0;
            if (op == OPCODE_CLOSE) begin
               stopped = 1'b1;
               push_word(KIND_CLOSE, 8'h00, 1'b0);
            end else begin
               is_ping = op == OPCODE_PING;
               is_text = !is_ping && op[0];
               if (is_ping) begin
                  push_word(KIND_PONG, PONG_HEAD, 1'b0);
                  push_word(KIND_PONG, 8'h00, 1'b0);
                  push_word(KIND_PONG, 8'h00, 1'b0);
                  push_word(KIND_PONG, 8'h00, 1'b1);
               end
               prs_phase = PH_HDR1;
            end
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = draw_gap(idle_req);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      model_byte(b);
      bytes_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_frame(input logic [7:0] head, input bit use_mask,
                             input int unsigned len, input bit use_ext);
      send_byte(head);
      if (use_ext || len >= 126) begin
         send_byte({use_mask, LEN7_EXT16});
         send_byte(len[15:8]);
         send_byte(len[7:0]);
      end else begin
         send_byte({use_mask, len[6:0]});
      end
      if (use_mask) repeat (4) send_byte(8'($urandom));
      repeat (len) send_byte(8'($urandom));
   endtask

   // keeps noise from halting the parser or opening huge frames
   function automatic logic [7:0] tame(input logic [7:0] b);
      case (prs_phase)
         PH_HDR0:   if (b[3:0] == OPCODE_CLOSE) b[0] = 1'b1;
         PH_HDR1:   if (b[6:0] == LEN7_EXT64) b[0] = 1'b0;
         PH_EXT_HI: b = {7'd0, b[0]};
         default:   ;
      endcase
      return b;
   endfunction

   task automatic test_directed_frames();
      send_byte({FIN_SET, OP_TEXT});
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame({FIN_SET, OP_TEXT}, 1'b0, 0, 1'b0);
      send_frame({FIN_SET, OP_TEXT}, 1'b1, 1, 1'b0);
      send_frame({FIN_SET, OP_BINARY}, 1'b0, 1, 1'b0);
      send_frame({4'h0, OP_TEXT}, 1'b0, 0, 1'b1);
   endtask

   task automatic test_ping();
      send_frame({FIN_SET, OPCODE_PING}, 1'b0, 0, 1'b0);
   endtask

   task automatic test_random_stream();
      int unsigned start;
      int unsigned pick;
      int unsigned len;
      logic [3:0]  op;
      start = bytes_sent;
      while (bytes_sent - start < 350) begin
         if ($urandom_range(0, 9) == 0) begin
            idle_req = $urandom_range(0, 2) != 0;
            idle_rsp = $urandom_range(0, 2) != 0;
         end
         if ($urandom_range(0, 99) < 85) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               op = 4'($urandom_range(0, 7) * 2 + 1);
               if (op == OPCODE_PING) op = OP_TEXT;
            end else if (pick < 8) begin
               op = OPCODE_PING;
            end else begin
               op = 4'($urandom_range(0, 7) * 2);
               if (op == OPCODE_CLOSE) op = OP_CONT;
            end
            pick = $urandom_range(0, 9);
            len = pick < 6 ? $urandom_range(0, 8) :
                  pick < 8 ? $urandom_range(0, 40) :
                  pick < 9 ? $urandom_range(0, 125) : $urandom_range(0, 300);
            send_frame({4'($urandom_range(0, 15)), op}, 1'($urandom_range(0, 1)),
                       len, pick == 9);
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(tame(8'($urandom)));
            while (prs_phase != PH_HDR0) send_byte(tame(8'($urandom)));
         end
      end
   endtask

   // close or 64-bit length ends parsing for good, so only one per run
   task automatic test_halt();
      idle_req = 1'b1;
      idle_rsp = 1'b1;
      if ($urandom_range(0, 1) != 0) begin
         send_byte({4'($urandom_range(0, 15)), OPCODE_CLOSE});
      end else begin
         send_byte({FIN_SET, OP_TEXT});
         send_byte({1'($urandom_range(0, 1)), LEN7_EXT64});
      end
      repeat (8) send_byte(8'($urandom));
   endtask

   initial begin
      int unsigned n;
      @(posedge clock);
      forever begin
         n = draw_gap(idle_rsp);
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      cmd_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: kind %0d data %0h last %0d", rsp_kind, rsp_data, rsp_last);
            errors++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_kind !== w.kind) begin
               $error("kind: expected %0d, actual %0d", w.kind, rsp_kind);
               errors++;
            end
            if (rsp_data !== w.data) begin
               $error("data: expected %0h, actual %0h", w.data, rsp_data);
               errors++;
            end
            if (rsp_last !== w.last) begin
               $error("last: expected %0d, actual %0d", w.last, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_ping();
      test_random_stream();
      test_halt();
      req_valid <= 1'b0;
      idle_rsp = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("websocket_frame_receiver_core test passed");
      else
         $display("websocket_frame_receiver_core test failed");
      $finish;
   end

endmodule
